// ----- sv/bfdh_pkg.sv -----
// Shared constants and codes for the double-hash Bloom filter.
package bfdh_pkg;

  localparam int MAX_BITS_DEF = 65536;
  localparam int WORD_W       = 32;
  localparam int WORD_SEL_W   = 5;
  localparam int MOD_W        = 17;
  localparam int HC_W         = 6;
  localparam int SEED_W       = 32;
  localparam int KEY_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int MOD_DIGITS   = 4;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_TEST  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED  = 2'd2;

  localparam logic [MOD_W-1:0]  NUM_BITS_RST   = 17'd65536;
  localparam logic [HC_W-1:0]   HASH_COUNT_RST = 6'd4;
  localparam logic [SEED_W-1:0] HASH_SEED_RST  = 32'd0;

  localparam logic [63:0] MM_C1   = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2   = 64'h4cf5ad432745937f;
  localparam logic [63:0] FMIX_K1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_K2 = 64'hc4ceb9fe1a85ec53;

  function automatic logic [63:0] xs33(input logic [63:0] v);
    return v ^ (v >> 33);
  endfunction

endpackage

// ----- sv/bfdh_hash.sv -----
// MurmurHash3 x64 128 of a 4-byte key, one 32x32 partial product per cycle.
module bfdh_hash
  import bfdh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KEY_W-1:0]  key,
  input  logic [SEED_W-1:0] seed,
  output logic              done,
  output logic [63:0]       ha,
  output logic [63:0]       hb
);

  localparam logic [2:0] H_IDLE = 3'd0;
  localparam logic [2:0] H_MUL  = 3'd1;
  localparam logic [2:0] H_ADD1 = 3'd2;
  localparam logic [2:0] H_ADD2 = 3'd3;
  localparam logic [2:0] H_FIN1 = 3'd4;
  localparam logic [2:0] H_FIN2 = 3'd5;

  logic [2:0]  state;
  logic [2:0]  step;
  logic [1:0]  phase;
  logic [63:0] x, h1, h2, acc, pp;
  logic [63:0] kc, r;
  logic [31:0] op_a, op_b;

  // multiplier constant per step
  always_comb begin
    case (step)
      3'd0:    kc = MM_C1;
      3'd1:    kc = MM_C2;
      3'd2:    kc = FMIX_K1;
      3'd3:    kc = FMIX_K2;
      3'd4:    kc = FMIX_K1;
      default: kc = FMIX_K2;
    endcase
  end

  // low 64 bits: alo*blo + ((alo*bhi + ahi*blo) << 32)
  always_comb begin
    case (phase)
      2'd0:    begin op_a = x[31:0];  op_b = kc[31:0];  end
      2'd1:    begin op_a = x[31:0];  op_b = kc[63:32]; end
      default: begin op_a = x[63:32]; op_b = kc[31:0];  end
    endcase
  end

  assign r = acc + {pp[31:0], 32'd0};

  always_ff @(posedge clk) begin
    pp <= 64'(op_a) * 64'(op_b);
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
      step  <= '0;
      phase <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        H_IDLE: begin
          if (start) begin
            x     <= 64'(key);
            step  <= '0;
            phase <= '0;
            state <= H_MUL;
          end
        end
        H_MUL: begin
          phase <= phase + 2'd1;
          if (phase == 2'd1) acc <= pp;
          if (phase == 2'd2) acc <= r;
          if (phase == 2'd3) begin
            phase <= '0;
            step  <= step + 3'd1;
            case (step)
              3'd0: x <= {r[32:0], r[63:33]};
              3'd1: begin
                h1    <= 64'(seed) ^ r ^ 64'd4;
                h2    <= 64'(seed) ^ 64'd4;
                state <= H_ADD1;
              end
              3'd2: x <= xs33(r);
              3'd3: begin
                h1 <= xs33(r);
                x  <= xs33(h2);
              end
              3'd4: x <= xs33(r);
              default: begin
                h2    <= xs33(r);
                state <= H_FIN1;
              end
            endcase
          end
        end
        H_ADD1: begin
          h1    <= h1 + h2;
          state <= H_ADD2;
        end
        H_ADD2: begin
          h2    <= h2 + h1;
          x     <= xs33(h1);
          state <= H_MUL;
        end
        H_FIN1: begin
          h1    <= h1 + h2;
          state <= H_FIN2;
        end
        H_FIN2: begin
          h2    <= h2 + h1;
          done  <= 1'b1;
          state <= H_IDLE;
        end
        default: state <= H_IDLE;
      endcase
    end
  end

  assign ha = h1;
  assign hb = h2;

endmodule

// ----- sv/bfdh_mod.sv -----
// 64-bit by 17-bit remainder, four restoring digits per cycle.
module bfdh_mod
  import bfdh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [63:0]      value,
  input  logic [MOD_W-1:0] modulus,
  output logic             done,
  output logic [MOD_W-1:0] rem
);

  localparam int CYCLES = 64 / MOD_DIGITS;
  localparam int CNT_W  = $clog2(CYCLES);

  logic [63:0]      sh;
  logic [MOD_W-1:0] r;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [MOD_W-1:0] r_next;

  always_comb begin
    logic [MOD_W:0] w;
    r_next = r;
    for (int i = 0; i < MOD_DIGITS; i++) begin
      w = {r_next, sh[63-i]};
      if (w >= {1'b0, modulus}) w = w - {1'b0, modulus};
      r_next = w[MOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sh  <= value;
        r   <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        r   <= r_next;
        sh  <= sh << MOD_DIGITS;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CYCLES - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = r;

endmodule

// ----- sv/bfdh_store.sv -----
// Filter bit store: 32-bit rows, one write and one registered read port.
module bfdh_store
  import bfdh_pkg::*;
#(
  parameter int ROWS  = MAX_BITS_DEF / WORD_W,
  parameter int ROW_W = 11
)
(
  input  logic              clk,
  input  logic [ROW_W-1:0]  rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ROW_W-1:0]  wr_addr,
  input  logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/bloom_filter_double_hash_top.sv -----
// Bloom filter top: config registers, control sequencer, hash, modulo and bit store.
//
// channel   ports                                    handshake
// config    wr_en, wr_index, wr_data                 write at edge with wr_en
// command   start, busy, action, key                 beat at edge with start & !busy
// result    done, maybe_present                      one-cycle strobe on done
//
// Add/test: hashing runs 6 multiplies on one 32x32 multiplier, plus the start
// handoff and the four add steps; then per position a remainder (start, digit
// steps, done), a row read and a check/write, for hash_count positions, busy
// high throughout (a test ends early on a miss).
// Clear and reset sweep all ceil(MAX_BITS/32) rows of the store one row a cycle
// (2048 at the default), busy high throughout. Results cannot be stalled.
module bloom_filter_double_hash_top
  import bfdh_pkg::*;
#(
  parameter int MAX_BITS = MAX_BITS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            action,
  input  logic [KEY_W-1:0]      key,
  output logic                  done,
  output logic                  maybe_present
);

  localparam int ROWS  = (MAX_BITS + WORD_W - 1) / WORD_W;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W = ROW_W + WORD_SEL_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;

  logic [MOD_W-1:0]  num_bits;
  logic [HC_W-1:0]   hash_count;
  logic [SEED_W-1:0] hash_seed;

  logic [2:0]        state;
  logic [1:0]        act_q;
  logic [KEY_W-1:0]  key_q;
  logic [HC_W-1:0]   n;
  logic [63:0]       cur, step_b;
  logic [IDX_W-1:0]  idx_q;
  logic [ROW_W-1:0]  clr_addr;
  logic [MOD_W-1:0]  m;

  logic              hash_start, hash_done;
  logic [63:0]       ha, hb;
  logic              mod_start, mod_done;
  logic [MOD_W-1:0]  rem;

  logic [ROW_W-1:0]  rd_addr, wr_addr;
  logic [WORD_W-1:0] rd_data, wr_data_m;
  logic              mem_we;
  logic              bit_set;
  logic [HC_W-1:0]   n_next;

  always_comb begin
    if (num_bits == '0)
      m = MOD_W'(1);
    else if (32'(num_bits) > 32'(MAX_BITS))
      m = MOD_W'(MAX_BITS);
    else
      m = num_bits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_bits   <= NUM_BITS_RST;
      hash_count <= HASH_COUNT_RST;
      hash_seed  <= HASH_SEED_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_NUM_BITS:   num_bits   <= wr_data[MOD_W-1:0];
        CFG_HASH_COUNT: hash_count <= wr_data[HC_W-1:0];
        CFG_HASH_SEED:  hash_seed  <= wr_data[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy    = (state != S_IDLE);
  assign bit_set = rd_data[idx_q[WORD_SEL_W-1:0]];
  assign n_next  = n + 1'b1;
  assign rd_addr = idx_q[IDX_W-1:WORD_SEL_W];

  always_comb begin
    mem_we    = 1'b0;
    wr_addr   = idx_q[IDX_W-1:WORD_SEL_W];
    wr_data_m = rd_data | (WORD_W'(1) << idx_q[WORD_SEL_W-1:0]);
    if (state == S_CLR) begin
      mem_we    = 1'b1;
      wr_addr   = clr_addr;
      wr_data_m = '0;
    end else if (state == S_CHK && act_q == ACT_ADD) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_addr   <= '0;
      done       <= 1'b0;
      hash_start <= 1'b0;
      mod_start  <= 1'b0;
    end else begin
      done       <= 1'b0;
      hash_start <= 1'b0;
      mod_start  <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act_q <= action;
            key_q <= key;
            n     <= '0;
            case (action) inside
              ACT_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLR;
              end
              ACT_ADD, ACT_TEST: begin
                if (hash_count == '0) begin
                  // no positions: test passes trivially
                  done          <= (action == ACT_TEST);
                  maybe_present <= 1'b1;
                end else begin
                  hash_start <= 1'b1;
                  state      <= S_HASH;
                end
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ROW_W'(ROWS - 1)) state <= S_IDLE;
        end
        S_HASH: begin
          if (hash_done) begin
            cur       <= ha;
            step_b    <= hb;
            mod_start <= 1'b1;
            state     <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            idx_q <= IDX_W'(rem);
            state <= S_RD;
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          n <= n_next;
          if (act_q == ACT_TEST && !bit_set) begin
            done          <= 1'b1;
            maybe_present <= 1'b0;
            state         <= S_IDLE;
          end else if (n_next == hash_count) begin
            done          <= (act_q == ACT_TEST);
            maybe_present <= 1'b1;
            state         <= S_IDLE;
          end else begin
            cur       <= cur + step_b;
            mod_start <= 1'b1;
            state     <= S_MOD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  bfdh_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (key_q),
    .seed  (hash_seed),
    .done  (hash_done),
    .ha    (ha),
    .hb    (hb)
  );

  // next position's sum feeds in the cycle mod_start is seen
  bfdh_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .value   (cur),
    .modulus (m),
    .done    (mod_done),
    .rem     (rem)
  );

  bfdh_store #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data_m)
  );

`ifndef ASSERT_OFF
  a_rd_chk: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |=> state == S_CHK) else $error("read not followed by check");
  a_mod_st: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == S_MOD) else $error("remainder outside mod wait");
  a_hash_st: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> state == S_HASH) else $error("hash done outside hash wait");
  a_we_src: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLR || (state == S_CHK && act_q == ACT_ADD)))
    else $error("unexpected store write");
`endif

endmodule

// ----- tb/bloom_filter_double_hash_top_tb.sv -----
// Self-checking testbench for the double-hash Bloom filter top.
`timescale 1ns / 1ps

module bloom_filter_double_hash_top_tb;
  import bfdh_pkg::*;

  localparam int STORE_BITS = 65536;
  localparam int IDLE_WAIT  = 1400;   // longer than the worst add (hash_count 63)
  localparam int WD_LIMIT   = 30000;
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef struct {
    logic [1:0]  act;
    logic [31:0] k;
    bit          known;
    bit          res;
  } cmd_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            action = ACT_ADD;
  logic [KEY_W-1:0]      key = '0;
  logic                  done;
  logic                  maybe_present;

  bloom_filter_double_hash_top i_dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .start(start), .busy(busy), .action(action), .key(key),
    .done(done), .maybe_present(maybe_present)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // predictor state
  bit          filt [STORE_BITS];
  logic [16:0] m_num_bits = NUM_BITS_RST;
  logic [5:0]  m_hash_cnt = HASH_COUNT_RST;
  logic [31:0] m_seed     = HASH_SEED_RST;

  bit          presence_q[$];
  logic [31:0] added_keys[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          beat_seen;

  function automatic logic [63:0] fmix(input logic [63:0] v);
    v ^= v >> 33;
    v *= FMIX_K1;
    v ^= v >> 33;
    v *= FMIX_K2;
    v ^= v >> 33;
    return v;
  endfunction

  function automatic void murmur_key(input logic [31:0] k, input logic [31:0] s,
                                     output logic [63:0] ha, output logic [63:0] hb);
    logic [63:0] h1, h2, k1;
    h1 = {32'd0, s};
    h2 = {32'd0, s};
    k1 = {32'd0, k} * MM_C1;
    k1 = (k1 << 31) | (k1 >> 33);
    k1 = k1 * MM_C2;
    h1 ^= k1;
    h1 ^= 64'd4;
    h2 ^= 64'd4;
    h1 += h2;
    h2 += h1;
    h1 = fmix(h1);
    h2 = fmix(h2);
    h1 += h2;
    h2 += h1;
    ha = h1;
    hb = h2;
  endfunction

  // updates the filter copy; returns 1 when a test result is due
  function automatic bit filter_update(input logic [1:0] act, input logic [31:0] k,
                                       output bit hit);
    logic [63:0] ha, hb, md, idx;
    hit = 1'b1;
    if (act == ACT_CLEAR) begin
      foreach (filt[i]) filt[i] = 1'b0;
      return 1'b0;
    end
    if (act == ACT_NONE) return 1'b0;
    murmur_key(k, m_seed, ha, hb);
    md = (m_num_bits == 0) ? 64'd1 : (m_num_bits > STORE_BITS) ? STORE_BITS : m_num_bits;
    for (int n = 0; n < m_hash_cnt; n++) begin
      idx = (ha + 64'(n) * hb) % md;
      if (act == ACT_ADD) filt[idx] = 1'b1;
      else if (!filt[idx]) begin
        hit = 1'b0;
        return 1'b1;
      end
    end
    return act == ACT_TEST;
  endfunction

  // one command beat; on return start is still high, at a rising edge
  task automatic send_cmd(input logic [1:0] act, input logic [31:0] k,
                          input bit known, input bit res);
    bit due, hit;
    start  <= 1'b1;
    action <= act;
    key    <= k;
    do @(posedge clk); while (busy);
    beat_seen = 1'b1;
    due = filter_update(act, k, hit);
    if (act == ACT_ADD) begin
      added_keys.push_back(k);
      if (added_keys.size() > 64) void'(added_keys.pop_front());
    end
    if (act == ACT_CLEAR) added_keys.delete();
    if (due) presence_q.push_back(known ? res : hit);
  endtask

  // wait until every result is in and the block is idle
  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (presence_q.size() != 0 || busy);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] nb, input logic [31:0] hc,
                            input logic [31:0] sd);
    wr_en <= 1'b1; wr_index <= CFG_NUM_BITS; wr_data <= nb;
    @(posedge clk);
    wr_index <= CFG_HASH_COUNT; wr_data <= hc;
    @(posedge clk);
    wr_index <= CFG_HASH_SEED; wr_data <= sd;
    @(posedge clk);
    wr_en <= 1'b0;
    beat_seen = 1'b1;
    m_num_bits = nb[16:0];
    m_hash_cnt = hc[5:0];
    m_seed     = sd;
  endtask

  // result checker: results cannot be held off
  always @(posedge clk) begin
    if (!rst && done) begin
      beat_seen = 1'b1;
      if (presence_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0b", $time, maybe_present);
        errors++;
      end else begin
        bit exp_hit;
        exp_hit = presence_q.pop_front();
        if (maybe_present !== exp_hit) begin
          $display("%0t: maybe_present expected %0b actual %0b", $time, exp_hit,
                   maybe_present);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (beat_seen) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    beat_seen = 1'b0;
    if (idle_cycles >= WD_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  cmd_row_t dir_rows[$] = '{
    '{ACT_TEST,  32'h0000_0000, 1, 0},   // empty store after reset
    '{ACT_TEST,  32'h7fff_ffff, 1, 0},
    '{ACT_ADD,   32'h0000_0000, 0, 0},
    '{ACT_TEST,  32'h0000_0000, 1, 1},
    '{ACT_ADD,   32'h8000_0000, 0, 0},
    '{ACT_ADD,   32'hffff_ffff, 0, 0},
    '{ACT_ADD,   32'h7fff_ffff, 0, 0},
    '{ACT_TEST,  32'h8000_0000, 1, 1},
    '{ACT_TEST,  32'hffff_ffff, 1, 1},
    '{ACT_TEST,  32'h7fff_ffff, 1, 1},
    '{ACT_TEST,  32'h1234_5678, 0, 0},
    '{ACT_NONE,  32'h5555_5555, 0, 0},   // unused action, ignored
    '{ACT_TEST,  32'haaaa_aaaa, 0, 0},
    '{ACT_CLEAR, 32'h0000_0000, 0, 0},
    '{ACT_TEST,  32'h0000_0000, 1, 0},
    '{ACT_TEST,  32'hffff_ffff, 1, 0}
  };

  int unsigned ph_bits [7] = '{65536, 1, 0, 131071, 97, 0, 65536};
  int unsigned ph_hc   [7] = '{4, 1, 0, 32, 63, 0, 3};
  int unsigned ph_items[7] = '{300, 100, 100, 150, 30, 320, 350};

  initial begin
    int burst, r;
    logic [1:0]  act;
    logic [31:0] k, nb, hc, sd;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].act, dir_rows[i].k, dir_rows[i].known, dir_rows[i].res);
    drain();

    for (int p = 0; p < 7; p++) begin
      nb = ph_bits[p];
      hc = ph_hc[p];
      sd = (p == 0) ? 32'd0 : (p == 1) ? 32'hffff_ffff : $urandom;
      if (p == 5) begin
        nb = $urandom_range(2000, 8);
        hc = $urandom_range(8, 1);
      end
      set_config(nb, hc, sd);
      burst = $urandom_range(30, 1);
      for (int i = 0; i < ph_items[p]; i++) begin
        r = $urandom_range(99);
        act = (r < 40) ? ACT_ADD : (r < 95) ? ACT_TEST : (r < 98) ? ACT_CLEAR : ACT_NONE;
        if (added_keys.size() != 0 && $urandom_range(1))
          k = added_keys[$urandom_range(added_keys.size() - 1)];
        else k = $urandom;
        send_cmd(act, k, 0, 0);
        if (--burst == 0) begin
          burst = $urandom_range(30, 1);
          if ($urandom_range(3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(20, 1)) @(posedge clk);
          end
        end
      end
      drain();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
sv/bfdh_pkg.sv
sv/bfdh_hash.sv
sv/bfdh_mod.sv
sv/bfdh_store.sv
sv/bloom_filter_double_hash_top.sv
tb/bloom_filter_double_hash_top_tb.sv
